FILE: rtl/core/ciq_pkg.sv
// Package for the channel interrupt queue: sizes, field widths, command codes
// and the record types that pass between the pipeline registers.
// Depends on nothing; the interfaces and the top level use its scoped names.
`timescale 1ns / 1ps

package ciq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int LINE_W    = 8;
  localparam int CODE_W    = 6;
  localparam int ENTRY_W   = LINE_W + CODE_W;
  localparam int CHAN_W    = 4;
  localparam int INTR_W    = 5;
  localparam int QCOUNT_W  = 6;

  localparam logic [INTR_W-1:0] CPU_INTR_OFFSET = INTR_W'(12);
  localparam logic [CODE_W-1:0] HIGH_PRIO_LAST  = CODE_W'(3);
  localparam logic [CODE_W-1:0] FAULTY_CODE     = CODE_W'(1);
  localparam logic [LINE_W-1:0] FAULTY_LINE     = LINE_W'(0);

  typedef enum logic {
    CMD_POST    = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_t;

  // Result fields known once the item has been processed; the dequeued entry
  // itself arrives from the entry store's registered read in the next cycle.
  typedef struct packed {
    logic              notify_cpu;
    logic [INTR_W-1:0] cpu_intr_number;
    logic              deq_valid;
    logic [CNT_W-1:0]  queue_count;
    logic              overflow_fault;
  } stage_t;

  typedef struct packed {
    logic                notify_cpu;
    logic [INTR_W-1:0]   cpu_intr_number;
    logic                deq_valid;
    logic [LINE_W-1:0]   deq_line;
    logic [CODE_W-1:0]   deq_code;
    logic [QCOUNT_W-1:0] queue_count;
    logic                overflow_fault;
  } result_t;

endpackage

FILE: rtl/core/ciq_in_if.sv
// Input channel of the channel interrupt queue: valid/ready plus the post or
// dequeue request. Depends on ciq_pkg.
`timescale 1ns / 1ps

interface ciq_in_if;
  logic                       valid;
  logic                       ready;
  ciq_pkg::cmd_t              cmd;
  logic [ciq_pkg::LINE_W-1:0] line_number;
  logic [ciq_pkg::CODE_W-1:0] intr_code;

  modport source (output valid, output cmd, output line_number, output intr_code,
                  input ready);
  modport sink   (input valid, input cmd, input line_number, input intr_code,
                  output ready);
endinterface

FILE: rtl/core/ciq_out_if.sv
// Result channel of the channel interrupt queue: valid/ready plus one result.
// Depends on ciq_pkg.
`timescale 1ns / 1ps

interface ciq_out_if;
  logic                         valid;
  logic                         ready;
  logic                         notify_cpu;
  logic [ciq_pkg::INTR_W-1:0]   cpu_intr_number;
  logic                         deq_valid;
  logic [ciq_pkg::LINE_W-1:0]   deq_line;
  logic [ciq_pkg::CODE_W-1:0]   deq_code;
  logic [ciq_pkg::QCOUNT_W-1:0] queue_count;
  logic                         overflow_fault;

  modport source (output valid, output notify_cpu, output cpu_intr_number,
                  output deq_valid, output deq_line, output deq_code,
                  output queue_count, output overflow_fault, input ready);
  modport sink   (input valid, input notify_cpu, input cpu_intr_number,
                  input deq_valid, input deq_line, input deq_code,
                  input queue_count, input overflow_fault, output ready);
endinterface

FILE: rtl/core/ciq_cfg_if.sv
// Configuration write channel of the channel interrupt queue: valid/ready and
// the channel number. Depends on ciq_pkg.
`timescale 1ns / 1ps

interface ciq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ciq_pkg::CHAN_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/ciq_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
`timescale 1ns / 1ps

module ciq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/channel_interrupt_queue.sv
// Top level of the channel interrupt queue: queue pointers, count, result
// pipeline and handshakes. Depends on ciq_pkg, the three channel interfaces
// and ciq_ram.
`timescale 1ns / 1ps

// Channel  | Direction | Carries
// ---------+-----------+----------------------------------------------------
// in_ch    | sink      | cmd, line_number, intr_code (post or dequeue)
// out_ch   | source    | one result per item: notify, interrupt number, entry
// cfg_ch   | sink      | channel number (ready is always high)
//
// A new item may be transferred on every clock edge while the output is not
// stalled. Each result passes through the middle stage and then the output
// register before it is presented on out_ch; the middle stage is there for
// the registered read of the entry store. A stalled result stays in the
// output register while one more item waits in the middle stage; only when
// both are held does in_ch.ready fall. Reset (rst_n, synchronous, active low)
// empties the queue and clears the channel number; the entry store itself is
// not cleared, as only written entries are ever read.

module channel_interrupt_queue (
  input  logic               clk,
  input  logic               rst_n,
  ciq_in_if.sink             in_ch,
  ciq_out_if.source          out_ch,
  ciq_cfg_if.sink            cfg_ch
);

  localparam logic [ciq_pkg::IDX_W-1:0] LAST_IDX  = ciq_pkg::IDX_W'(ciq_pkg::QUEUE_DEPTH - 1);
  localparam logic [ciq_pkg::CNT_W-1:0] FULL_CNT  = ciq_pkg::CNT_W'(ciq_pkg::QUEUE_DEPTH);
  localparam logic [ciq_pkg::CNT_W-1:0] ONE_CNT   = ciq_pkg::CNT_W'(1);
  localparam logic [ciq_pkg::CNT_W-1:0] ZERO_CNT  = '0;

  // Configuration register.
  logic [ciq_pkg::CHAN_W-1:0] channel_number_r;

  // Queue control state.
  logic [ciq_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [ciq_pkg::IDX_W-1:0] tail_r, tail_nxt;
  logic [ciq_pkg::CNT_W-1:0] count_r, count_nxt;

  // Middle stage (waits for the entry store read) and output register.
  logic              mid_valid_r;
  ciq_pkg::stage_t   mid_r, mid_nxt;
  logic              out_valid_r;
  ciq_pkg::result_t  out_r, out_nxt;

  // Entry store access.
  logic                          ram_we;
  logic [ciq_pkg::IDX_W-1:0]     ram_waddr;
  logic [ciq_pkg::ENTRY_W-1:0]   ram_wdata;
  logic                          ram_re;
  logic [ciq_pkg::ENTRY_W-1:0]   ram_rdata;

  logic in_xfer;
  logic mid_adv;
  logic [ciq_pkg::IDX_W-1:0] tail_inc;
  logic [ciq_pkg::IDX_W-1:0] head_inc;

  // The middle stage moves on whenever the output register is free or is
  // being emptied in this cycle; the input is open whenever the middle stage
  // is empty or moving on.
  assign mid_adv     = mid_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !mid_valid_r || mid_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + ciq_pkg::IDX_W'(1);
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + ciq_pkg::IDX_W'(1);

  // Queue update for the item being transferred. The dequeue read is issued
  // at the old head; its data is registered inside the store and joins the
  // rest of the result held in the middle stage.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = {in_ch.line_number, in_ch.intr_code};
    ram_re    = 1'b0;

    mid_nxt.notify_cpu      = 1'b0;
    mid_nxt.cpu_intr_number = ciq_pkg::INTR_W'(channel_number_r) + ciq_pkg::CPU_INTR_OFFSET;
    mid_nxt.deq_valid       = 1'b0;
    mid_nxt.overflow_fault  = 1'b0;

    if (in_xfer) begin
      unique case (in_ch.cmd)
        ciq_pkg::CMD_POST: begin
          priority if (in_ch.intr_code <= ciq_pkg::HIGH_PRIO_LAST) begin
            // High-priority code flushes the queue and becomes its only entry.
            ram_we    = 1'b1;
            head_nxt  = '0;
            tail_nxt  = '0;
            count_nxt = ONE_CNT;
            mid_nxt.notify_cpu = 1'b1;
          end else if (count_r >= FULL_CNT) begin
            // Overflow: the posted item is dropped and the channel is
            // reported faulty through a single entry.
            ram_we    = 1'b1;
            ram_wdata = {ciq_pkg::FAULTY_LINE, ciq_pkg::FAULTY_CODE};
            head_nxt  = '0;
            tail_nxt  = '0;
            count_nxt = ONE_CNT;
            mid_nxt.notify_cpu     = 1'b1;
            mid_nxt.overflow_fault = 1'b1;
          end else if (count_r != ZERO_CNT) begin
            ram_we    = 1'b1;
            ram_waddr = tail_inc;
            tail_nxt  = tail_inc;
            count_nxt = count_r + ONE_CNT;
          end else begin
            // First entry of an empty queue wakes the CPU.
            ram_we    = 1'b1;
            head_nxt  = '0;
            tail_nxt  = '0;
            count_nxt = ONE_CNT;
            mid_nxt.notify_cpu = 1'b1;
          end
        end
        ciq_pkg::CMD_DEQUEUE: begin
          if (count_r != ZERO_CNT) begin
            ram_re            = 1'b1;
            mid_nxt.deq_valid = 1'b1;
            count_nxt         = count_r - ONE_CNT;
            if (count_r == ONE_CNT) begin
              head_nxt = '0;
              tail_nxt = '0;
            end else begin
              head_nxt = head_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end

    mid_nxt.queue_count = count_nxt;
  end

  // Output record: the dequeued entry is shown only when one was returned.
  always_comb begin
    out_nxt.notify_cpu      = mid_r.notify_cpu;
    out_nxt.cpu_intr_number = mid_r.cpu_intr_number;
    out_nxt.deq_valid       = mid_r.deq_valid;
    out_nxt.deq_line        = mid_r.deq_valid ?
                              ram_rdata[ciq_pkg::ENTRY_W-1:ciq_pkg::CODE_W] : '0;
    out_nxt.deq_code        = mid_r.deq_valid ? ram_rdata[ciq_pkg::CODE_W-1:0] : '0;
    out_nxt.queue_count     = ciq_pkg::QCOUNT_W'(mid_r.queue_count);
    out_nxt.overflow_fault  = mid_r.overflow_fault;
  end

  ciq_ram #(
    .WIDTH (ciq_pkg::ENTRY_W),
    .DEPTH (ciq_pkg::QUEUE_DEPTH)
  ) u_entry_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_number_r <= '0;
      head_r           <= '0;
      tail_r           <= '0;
      count_r          <= '0;
      mid_valid_r      <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        channel_number_r <= cfg_ch.data;
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (in_xfer) begin
        mid_valid_r <= 1'b1;
      end else if (mid_adv) begin
        mid_valid_r <= 1'b0;
      end
      if (mid_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mid_r <= mid_nxt;
    end
    if (mid_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.notify_cpu      = out_r.notify_cpu;
  assign out_ch.cpu_intr_number = out_r.cpu_intr_number;
  assign out_ch.deq_valid       = out_r.deq_valid;
  assign out_ch.deq_line        = out_r.deq_line;
  assign out_ch.deq_code        = out_r.deq_code;
  assign out_ch.queue_count     = out_r.queue_count;
  assign out_ch.overflow_fault  = out_r.overflow_fault;

endmodule
